FILE: rtl/core/lfu_pkg.sv
`default_nettype none

package lfu_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LIM_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int CFG_W    = 5;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(16);

  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic             we;
    logic [CFG_W-1:0] capacity;
  } cfg_t;

  typedef enum logic [2:0] {
    S_FETCH,
    S_LOOK,
    S_SCAN,
    S_TOUCH,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/lfu_queue.sv
`default_nettype none

module lfu_queue
  import lfu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       q_valid,
  input  wire logic  q_pop,
  output item_t      q_item
);

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready = (count != QCNT_W'(QDEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + QPTR_W'(1);
      if (pop)  rptr <= rptr + QPTR_W'(1);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= in_item;
  end

endmodule

`default_nettype wire

FILE: rtl/core/lfu_engine.sv
`default_nettype none

module lfu_engine
  import lfu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cfg_t             cfg,
  input  wire logic [CFG_W-1:0] capacity,
  input  wire logic             q_valid,
  input  wire item_t            q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_found,
  output logic [DATA_W-1:0]     out_value
);

  function automatic logic [LIM_W-1:0] eff_lim(input logic [CFG_W-1:0] c);
    if (32'(c) > 32'(CAPACITY)) return LIM_W'(CAPACITY);
    else return LIM_W'(c);
  endfunction

  state_t state, state_next;

  logic [CAPACITY-1:0] valid;
  logic [DATA_W-1:0]   ent_key   [CAPACITY];
  logic [DATA_W-1:0]   ent_val   [CAPACITY];
  logic [DATA_W-1:0]   ent_cnt   [CAPACITY];
  logic [DATA_W-1:0]   ent_stamp [CAPACITY];
  logic [DATA_W-1:0]   use_clock;

  logic              op_mode;
  logic [DATA_W-1:0] op_key;
  logic [DATA_W-1:0] op_val;
  logic              hit;
  logic              ins;
  logic [IDX_W-1:0]  slot;
  logic [DATA_W-1:0] res_val;
  logic [IDX_W-1:0]  best_idx;
  logic [DATA_W-1:0] best_cnt;
  logic [DATA_W-1:0] best_stamp;
  logic [LIM_W-1:0]  scan_idx;

  logic [LIM_W-1:0]  lim;
  logic [LIM_W-1:0]  lim_new;
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] free_vec;
  logic              hit_any;
  logic              free_any;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [DATA_W-1:0] rd_cnt;
  logic [DATA_W-1:0] rd_stamp;
  logic              take;
  logic              out_load;

  assign lim     = eff_lim(capacity);
  assign lim_new = eff_lim(cfg.capacity);

  // key match lanes and free-slot lanes
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i]  = valid[i] && (ent_key[i] == op_key);
      free_vec[i] = !valid[i] && (32'(i) < 32'(lim));
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit_vec[i])  hit_idx  = IDX_W'(i);
      if (free_vec[i]) free_idx = IDX_W'(i);
    end
  end

  assign hit_any  = |hit_vec;
  assign free_any = |free_vec;

  assign rd_cnt   = ent_cnt[rd_idx];
  assign rd_stamp = ent_stamp[rd_idx];
  assign take     = (rd_cnt < best_cnt) ||
                    ((rd_cnt == best_cnt) && (rd_stamp < best_stamp));

  always_comb begin
    state_next = state;
    unique case (state)
      S_FETCH: if (q_valid) state_next = S_LOOK;
      S_LOOK: begin
        if (hit_any)                     state_next = S_TOUCH;
        else if (op_mode && lim != '0)   state_next = free_any ? S_TOUCH : S_SCAN;
        else                             state_next = S_OUT;
      end
      S_SCAN:  if (scan_idx == lim) state_next = S_TOUCH;
      S_TOUCH: state_next = S_OUT;
      S_OUT:   if (!out_valid || out_ready) state_next = S_FETCH;
      default: state_next = S_FETCH;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    rd_idx   = slot;
    unique case (state)
      S_FETCH: q_pop = q_valid;
      S_LOOK:  rd_idx = '0;
      S_SCAN:  rd_idx = scan_idx[IDX_W-1:0];
      S_TOUCH: rd_idx = slot;
      S_OUT:   out_load = !out_valid || out_ready;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FETCH;
      valid     <= '0;
      use_clock <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.we) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (32'(i) >= 32'(lim_new)) valid[i] <= 1'b0;
        end
      end
      if (state == S_TOUCH) begin
        if (ins) valid[slot] <= 1'b1;
        use_clock <= use_clock + DATA_W'(1);
      end
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_mode <= q_item.mode;
      op_key  <= q_item.key;
      op_val  <= q_item.value;
    end
    if (state == S_LOOK) begin
      hit        <= hit_any;
      ins        <= !hit_any && op_mode && (lim != '0);
      slot       <= hit_any ? hit_idx : free_idx;
      res_val    <= '1;
      best_idx   <= '0;
      best_cnt   <= rd_cnt;
      best_stamp <= rd_stamp;
      scan_idx   <= LIM_W'(1);
    end
    if (state == S_SCAN) begin
      if (scan_idx != lim) begin
        if (take) begin
          best_idx   <= scan_idx[IDX_W-1:0];
          best_cnt   <= rd_cnt;
          best_stamp <= rd_stamp;
        end
        scan_idx <= scan_idx + LIM_W'(1);
      end else begin
        slot <= best_idx;
      end
    end
    if (state == S_TOUCH) begin
      ent_stamp[slot] <= use_clock;
      if (ins) begin
        ent_key[slot] <= op_key;
        ent_val[slot] <= op_val;
        ent_cnt[slot] <= DATA_W'(1);
        res_val       <= op_val;
      end else begin
        if (op_mode) ent_val[slot] <= op_val;
        if (rd_cnt != '1) ent_cnt[slot] <= rd_cnt + DATA_W'(1);
        res_val <= op_mode ? op_val : ent_val[slot];
      end
    end
    if (out_load) begin
      out_found <= hit;
      out_value <= res_val;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lfu_cache_replacement.sv
// LFU key-value store, least recent use breaks count ties.
// Sequence: the engine steps each item through fetch, lookup, update and output; a miss or
//   an ignored set skips update, and an insert into a full store first scans the slots in use.
// The engine sequencer takes one item at a time and waits in output while a result is stalled;
//   a 2-item input queue keeps accepting while the engine works.
// Reset: synchronous, active high; all entries invalid, capacity 16, use clock zero.
`default_nettype none

module lfu_cache_replacement
  import lfu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // mode[0], key[32:1], value[64:33], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata   // found[0], read_value[32:1], zero pad
);

  logic [CFG_W-1:0]  capacity;
  cfg_t              cfg;
  item_t             in_item;
  item_t             q_item;
  logic              q_valid;
  logic              q_pop;
  logic              out_found;
  logic [DATA_W-1:0] out_value;

  assign pready = 1'b1;
  assign cfg.we = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign cfg.capacity = pwdata[CFG_W-1:0];
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CFG_W){1'b0}}, capacity} : '0;

  always_ff @(posedge clk) begin
    if (rst) capacity <= CAPACITY_RESET;
    else if (cfg.we) capacity <= cfg.capacity;
  end

  assign in_item.mode  = s_tdata[0];
  assign in_item.key   = s_tdata[32:1];
  assign in_item.value = s_tdata[64:33];

  lfu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  lfu_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .capacity  (capacity),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_found (out_found),
    .out_value (out_value)
  );

  assign m_tdata = {7'b0, out_value, out_found};

endmodule

`default_nettype wire

FILE: rtl/core/lfu_checker.sv
`default_nettype none

module lfu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  logic [3:0] pending;

  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else pending <= pending + 4'(s_tvalid && s_tready) - 4'(m_tvalid && m_tready);
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 4'd0)
    else $error("result without pending item");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:33] == 7'd0)
    else $error("nonzero pad bits in result");

  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(s_tvalid))
    else $error("input ready dropped without an accept");

endmodule

bind lfu_cache_replacement lfu_checker u_lfu_checker (.*);

`default_nettype wire
